### design/imac_pkg.sv
// Shared constants, step table and mode codes for the IMA ADPCM codec.
`default_nettype none

package imac_pkg;

	localparam int SampleW = 16;
	localparam int IndexW  = 7;
	localparam int StepW   = 15;
	localparam int NibW    = 4;
	localparam int ByteW   = 8;

	localparam logic [IndexW-1:0] MaxIndex = 7'd88;

	localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
	localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

	// codec_mode register codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [StepW-1:0] STEP_TABLE [0:88] = '{
		15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
		15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
		15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
		15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
		15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
		15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
		15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
		15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
		15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
		15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
		15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
		15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
		15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	// Quantizer step for an index; indexes past the top clamp to the last entry.
	function automatic logic [StepW-1:0] step_size(input logic [IndexW-1:0] idx);
		logic [IndexW-1:0] i;
		i = (idx > MaxIndex) ? MaxIndex : idx;
		return STEP_TABLE[i];
	endfunction

	// Index adaptation: -1 for magnitudes 0..3, else 2, 4, 6, 8.
	function automatic logic signed [IndexW:0] index_adjust(input logic [2:0] mag);
		logic signed [IndexW:0] a;
		if (!mag[2]) begin
			a = -8'sd1;
		end else begin
			a = $signed({5'd0, mag[1:0], 1'b0}) + 8'sd2;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

### design/ima_adpcm_codec_core.sv
// IMA ADPCM encoder/decoder core with shared predictor state and mode register.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  config  | cfg_we, cfg_wdata (codec_mode)                    | in
//  input   | in_valid/in_ready, pcm_sample, code_byte,         | in
//          | end_of_buffer, restart                            |
//  output  | out_valid/out_ready, code_byte_out, sample_out,   | out
//          | last_out                                          |
//
// An accepted word sits in the s1 register; unless a full output register holds
// the engine, one nibble is processed per cycle by the quantize/reconstruct
// logic into the output register or pending nibble. Encode has one nibble per
// word; decode does low, then high from the predictor/step index the low left.
// Reset clears predictor, step index, pending nibble, mode and all valids.
// A full output register that is not taken holds the engine; the input side
// takes a new word in the same cycle the s1 word retires.
`default_nettype none

module ima_adpcm_codec_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	// input words
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  pcm_sample,
	input  wire logic [7:0]          code_byte,
	input  wire logic                end_of_buffer,
	input  wire logic                restart,
	// output words
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               code_byte_out,
	output logic signed [15:0]       sample_out,
	output logic                     last_out
);

	// configuration
	logic codec_mode_q;

	// codec state
	logic signed [imac_pkg::SampleW-1:0] pred_q;
	logic [imac_pkg::IndexW-1:0]         idx_q;
	logic [imac_pkg::NibW-1:0]           pend_q;
	logic                                half_q;

	// input stage
	logic                                valid_s1;
	logic                                nib_sel_s1;   // 0: low nibble, 1: high nibble
	logic signed [imac_pkg::SampleW-1:0] sample_s1;
	logic [imac_pkg::ByteW-1:0]          byte_s1;
	logic                                eob_s1;
	logic                                restart_s1;

	// output register
	logic                                out_valid_q;
	logic [imac_pkg::ByteW-1:0]          code_byte_q;
	logic signed [imac_pkg::SampleW-1:0] sample_q;
	logic                                last_q;

	// engine
	logic                                clr;
	logic signed [imac_pkg::SampleW-1:0] pred_eff;
	logic [imac_pkg::IndexW-1:0]         idx_eff;
	logic                                half_eff;
	logic [imac_pkg::StepW-1:0]          step;
	logic                                decode;
	logic signed [16:0]                  diff;
	logic [16:0]                         mag0, mag1, mag2;
	logic [2:0]                          enc_mag;
	logic [imac_pkg::NibW-1:0]           code;
	logic [18:0]                         prod;
	logic [16:0]                         delta;
	logic signed [17:0]                  pred_sum;
	logic signed [imac_pkg::SampleW-1:0] pred_new;
	logic signed [imac_pkg::IndexW:0]    idx_sum;
	logic [imac_pkg::IndexW-1:0]         idx_new;
	logic                                produce;
	logic                                out_free;
	logic                                go;
	logic                                retire;

	assign decode   = (codec_mode_q == imac_pkg::MODE_DECODE);
	// restart applies only ahead of the first nibble of a word
	assign clr      = restart_s1 & ~nib_sel_s1;
	assign pred_eff = clr ? '0 : pred_q;
	assign idx_eff  = clr ? '0 : idx_q;
	assign half_eff = clr ? 1'b0 : half_q;
	assign step     = imac_pkg::step_size(idx_eff);

	always_comb begin
		// encoder quantizer: sign, then three compare/subtract steps
		diff    = 17'(sample_s1) - 17'(pred_eff);
		mag0    = diff[16] ? 17'(-diff) : 17'(diff);
		enc_mag[2] = (mag0 >= 17'(step));
		mag1    = enc_mag[2] ? (mag0 - 17'(step)) : mag0;
		enc_mag[1] = (mag1 >= 17'(step >> 1));
		mag2    = enc_mag[1] ? (mag1 - 17'(step >> 1)) : mag1;
		enc_mag[0] = (mag2 >= 17'(step >> 2));

		if (decode) begin
			code  = nib_sel_s1 ? byte_s1[7:4] : byte_s1[3:0];
			delta = 17'(step >> 3)
				+ (code[2] ? 17'(step)      : 17'd0)
				+ (code[1] ? 17'(step >> 1) : 17'd0)
				+ (code[0] ? 17'(step >> 2) : 17'd0);
			prod  = '0;
		end else begin
			code  = {diff[16], enc_mag};
			prod  = 19'({code[2:0], 1'b1}) * 19'(step);
			delta = 17'(prod[18:3]);
		end

		pred_sum = code[3] ? (18'(pred_eff) - $signed({1'b0, delta}))
		                   : (18'(pred_eff) + $signed({1'b0, delta}));
		if (pred_sum > 18'(imac_pkg::SampleMax)) begin
			pred_new = imac_pkg::SampleMax;
		end else if (pred_sum < 18'(imac_pkg::SampleMin)) begin
			pred_new = imac_pkg::SampleMin;
		end else begin
			pred_new = pred_sum[15:0];
		end

		idx_sum = $signed({1'b0, idx_eff}) + imac_pkg::index_adjust(code[2:0]);
		if (idx_sum < 0) begin
			idx_new = '0;
		end else if (idx_sum > $signed({1'b0, imac_pkg::MaxIndex})) begin
			idx_new = imac_pkg::MaxIndex;
		end else begin
			idx_new = idx_sum[imac_pkg::IndexW-1:0];
		end
	end

	// encode with nothing pending and no end mark only parks the nibble
	assign produce  = decode | half_eff | eob_s1;
	assign out_free = ~out_valid_q | out_ready;
	assign go       = valid_s1 & (~produce | out_free);
	assign retire   = go & (~decode | nib_sel_s1);
	assign in_ready = ~valid_s1 | retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= imac_pkg::MODE_ENCODE;
		end else if (cfg_we) begin
			codec_mode_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			nib_sel_s1 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1   <= 1'b1;
				nib_sel_s1 <= 1'b0;
			end else if (retire) begin
				valid_s1   <= 1'b0;
				nib_sel_s1 <= 1'b0;
			end else if (go) begin
				nib_sel_s1 <= 1'b1;   // decode: move on to high nibble
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1  <= pcm_sample;
			byte_s1    <= code_byte;
			eob_s1     <= end_of_buffer;
			restart_s1 <= restart;
		end
	end

	// codec state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= '0;
			idx_q  <= '0;
			pend_q <= '0;
			half_q <= 1'b0;
		end else if (go) begin
			pred_q <= pred_new;
			idx_q  <= idx_new;
			if (decode || half_eff) begin
				pend_q <= '0;
				half_q <= 1'b0;
			end else if (!eob_s1) begin
				pend_q <= code;
				half_q <= 1'b1;
			end else begin
				pend_q <= clr ? '0 : pend_q;
				half_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && produce) begin
			if (decode) begin
				code_byte_q <= '0;
				sample_q    <= pred_new;
				last_q      <= nib_sel_s1 & eob_s1;
			end else begin
				code_byte_q <= half_eff ? {code, pend_q} : {4'd0, code};
				sample_q    <= '0;
				last_q      <= eob_s1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign code_byte_out = code_byte_q;
	assign sample_out    = sample_q;
	assign last_out      = last_q;

endmodule

`default_nettype wire
